FILE: hw/rtl/mnts_pkg.sv
// Shared constants, codes and types of the Morton neighbour table search core.
package mnts_pkg;

  localparam int DEF_LAYERS = 8;
  localparam int DEF_LAYER_DEPTH = 1024;
  localparam int CODE_W = 63;
  localparam int AXIS_W = 21;
  localparam int FOUND_INDEX_W = 10;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_NEIGHBOUR = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [2:0] DIR_LIMIT = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRC_WAIT,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic empty;
    logic equal;
    logic less;
  } cmp_flags_t;

endpackage

FILE: hw/rtl/mnts_morton_step.sv
// Morton decode, one-cell step along an axis, and re-encode.
module mnts_morton_step (
  input  logic [mnts_pkg::CODE_W-1:0] src,
  input  logic [2:0]                  direction,
  output logic [mnts_pkg::CODE_W-1:0] key,
  output logic                        ok
);
  import mnts_pkg::*;

  logic [AXIS_W-1:0] cx, cy, cz, sel, stepped, nx, ny, nz;

  always_comb begin
    for (int i = 0; i < AXIS_W; i++) begin
      cx[i] = src[3*i];
      cy[i] = src[3*i+1];
      cz[i] = src[3*i+2];
    end
  end

  always_comb begin
    case (direction[2:1])
      AXIS_X: sel = cx;
      AXIS_Y: sel = cy;
      default: sel = cz;
    endcase
  end

  always_comb begin
    if (direction[0] == 1'b0) begin
      ok = (sel != {AXIS_W{1'b1}});
      stepped = sel + AXIS_W'(1);
    end else begin
      ok = (sel != {AXIS_W{1'b0}});
      stepped = sel - AXIS_W'(1);
    end
  end

  assign nx = (direction[2:1] == AXIS_X) ? stepped : cx;
  assign ny = (direction[2:1] == AXIS_Y) ? stepped : cy;
  assign nz = ((direction[2:1] != AXIS_X) && (direction[2:1] != AXIS_Y)) ? stepped : cz;

  always_comb begin
    for (int i = 0; i < AXIS_W; i++) begin
      key[3*i]   = nx[i];
      key[3*i+1] = ny[i];
      key[3*i+2] = nz[i];
    end
  end

endmodule

FILE: hw/rtl/mnts_bound_unit.sv
// Shared binary search unit: midpoint, entry compare and bound update.
module mnts_bound_unit #(
  parameter int IDX_W = 10
) (
  input  logic [IDX_W+1:0]            lo,
  input  logic [IDX_W+1:0]            hi,
  input  logic [IDX_W-1:0]            mid_held,
  input  logic [mnts_pkg::CODE_W-1:0] entry,
  input  logic [mnts_pkg::CODE_W-1:0] key,
  output logic [IDX_W-1:0]            mid,
  output logic [IDX_W+1:0]            lo_next,
  output logic [IDX_W+1:0]            hi_next,
  output mnts_pkg::cmp_flags_t        flags
);
  import mnts_pkg::*;

  logic [IDX_W+1:0] sum;

  assign sum = lo + hi;
  assign mid = sum[IDX_W:1];
  assign lo_next = {2'b00, mid_held} + (IDX_W+2)'(1);
  assign hi_next = {2'b00, mid_held} - (IDX_W+2)'(1);

  always_comb begin
    flags.empty = ($signed(lo) > $signed(hi));
    flags.equal = (entry == key);
    flags.less = (entry < key);
  end

endmodule

FILE: hw/rtl/morton_neighbour_table_search_core.sv
// Top level of the Morton neighbour table search core.
// Usage: each layer holds a sorted table of 63-bit Morton codes, loaded in
// order by write transactions (func 0), which also set the layer's count.
// A search transaction (func 1) looks for code in the layer; a neighbour
// transaction (func 2) steps entry node_index one cell along direction and
// looks for the result. Every input transaction gives exactly one result
// transaction with found and found_index.
// Input and output channels use valid and ready; in_ready is high while the
// sequencer is idle, so one transaction is worked on at a time.
// A write is done in the dispatch state, which then goes to finish. A search
// probes the layer by binary search, at most 11 probes for 1024 entries;
// each probe is a memory read followed by a compare in the single shared
// search unit, and a search that misses ends on a probe that finds the
// range empty. A neighbour transaction first reads the source entry and
// steps it. The next transaction is accepted in the cycle after the result
// is loaded.
// Reset clears the layer counts and out_valid; table contents
// are undefined until written. While the receiver stalls, the result waits
// in the output register and one more transaction can be accepted and
// worked on; it then holds until the output register is free.
module morton_neighbour_table_search_core #(
  parameter int LAYERS = mnts_pkg::DEF_LAYERS,
  parameter int LAYER_DEPTH = mnts_pkg::DEF_LAYER_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         func,
  input  logic [2:0]                         layer,
  input  logic [9:0]                         node_index,
  input  logic [mnts_pkg::CODE_W-1:0]        code,
  input  logic [2:0]                         direction,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [mnts_pkg::FOUND_INDEX_W-1:0] found_index
);
  import mnts_pkg::*;

  localparam int IDX_W = $clog2(LAYER_DEPTH);
  localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int ENTRIES = LAYERS * LAYER_DEPTH;
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int SW = IDX_W + 2;
  localparam int CNT_W = IDX_W + 1;

  state_t state, state_next;

  logic [1:0]        op_func;
  logic [2:0]        op_layer;
  logic [9:0]        op_node;
  logic [CODE_W-1:0] op_code;
  logic [2:0]        op_dir;

  logic [CODE_W-1:0] mem [ENTRIES];
  logic [CODE_W-1:0] rdata;
  logic [CNT_W-1:0]  layer_count [LAYERS];

  logic [CODE_W-1:0] key;
  logic [SW-1:0]     lo, hi;
  logic [IDX_W-1:0]  mid;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;

  logic [LAYER_W+2:0]  layer_ext;
  logic [LAYER_W-1:0]  lidx;
  logic [IDX_W+10:0]   node_ext;
  logic [IDX_W-1:0]    nidx;
  logic [CNT_W-1:0]    cur_count;
  logic                layer_ok, node_ok, src_loaded, dir_ok;
  logic [ADDR_W-1:0]   base, mem_addr;
  logic [IDX_W-1:0]    addr_idx;
  logic [SW-1:0]       hi_init;
  logic                mem_we, mem_re, out_load;
  logic [IDX_W+9:0]    idx_wide;

  logic [CODE_W-1:0] step_key;
  logic              step_ok;
  logic [IDX_W-1:0]  mid_calc;
  logic [SW-1:0]     lo_next, hi_next;
  cmp_flags_t        flags;

  mnts_morton_step u_step (
    .src       (rdata),
    .direction (op_dir),
    .key       (step_key),
    .ok        (step_ok)
  );

  mnts_bound_unit #(
    .IDX_W (IDX_W)
  ) u_bound (
    .lo       (lo),
    .hi       (hi),
    .mid_held (mid),
    .entry    (rdata),
    .key      (key),
    .mid      (mid_calc),
    .lo_next  (lo_next),
    .hi_next  (hi_next),
    .flags    (flags)
  );

  assign layer_ext = {{LAYER_W{1'b0}}, op_layer};
  assign layer_ok = (layer_ext < LAYERS);
  assign lidx = layer_ext[LAYER_W-1:0];
  assign node_ext = {{(IDX_W+1){1'b0}}, op_node};
  assign node_ok = (node_ext < LAYER_DEPTH);
  assign nidx = node_ext[IDX_W-1:0];
  assign cur_count = layer_count[lidx];
  assign src_loaded = (node_ext < {10'b0, cur_count});
  assign dir_ok = (op_dir < DIR_LIMIT);
  assign base = ADDR_W'(int'(lidx) * LAYER_DEPTH);
  assign hi_init = {1'b0, cur_count} - SW'(1);
  assign mem_addr = base + ADDR_W'(addr_idx);
  assign idx_wide = {10'b0, hit_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if ((op_func == FUNC_SEARCH) && layer_ok) begin
          state_next = ST_PROBE;
        end else if ((op_func == FUNC_NEIGHBOUR) && layer_ok && src_loaded && dir_ok) begin
          state_next = ST_SRC_WAIT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SRC_WAIT: state_next = step_ok ? ST_PROBE : ST_FINISH;
      ST_PROBE: state_next = flags.empty ? ST_FINISH : ST_CMP;
      ST_CMP: state_next = flags.equal ? ST_FINISH : ST_PROBE;
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    out_load = 1'b0;
    addr_idx = nidx;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DISPATCH: begin
        mem_we = (op_func == FUNC_WRITE) && layer_ok && node_ok;
        mem_re = (op_func == FUNC_NEIGHBOUR) && layer_ok && src_loaded && dir_ok;
      end
      ST_PROBE: begin
        addr_idx = mid_calc;
        mem_re = !flags.empty;
      end
      ST_FINISH: out_load = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= op_code;
    if (mem_re) rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAYERS; i++) layer_count[i] <= '0;
    end else if (mem_we) begin
      layer_count[lidx] <= {1'b0, nidx} + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func <= func;
      op_layer <= layer;
      op_node <= node_index;
      op_code <= code;
      op_dir <= direction;
    end
    case (state)
      ST_DISPATCH: begin
        hit <= 1'b0;
        hit_idx <= '0;
        key <= op_code;
        lo <= '0;
        hi <= hi_init;
      end
      ST_SRC_WAIT: key <= step_key;
      ST_PROBE: mid <= mid_calc;
      ST_CMP: begin
        if (flags.equal) begin
          hit <= 1'b1;
          hit_idx <= mid;
        end else if (flags.less) begin
          lo <= lo_next;
        end else begin
          hi <= hi_next;
        end
      end
      default: hit <= hit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found <= hit;
      found_index <= idx_wide[FOUND_INDEX_W-1:0];
    end
  end

endmodule
